// ===== rtl/weighted_grid_neighbour_expander_unit_macros.svh =====
// Assertion macros for the neighbour expander.
// Both expect clk and rst_n in scope.
`ifndef WEIGHTED_GRID_NEIGHBOUR_EXPANDER_UNIT_MACROS_SVH
`define WEIGHTED_GRID_NEIGHBOUR_EXPANDER_UNIT_MACROS_SVH

// same-cycle implication
`define WGNE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WGNE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wgne_pkg.sv =====
package wgne_pkg;

  localparam int ID_BITS_DEF     = 20;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam int NODE_W     = 20;
  localparam int WEIGHT_W   = 8;
  localparam int COST_W     = 17;
  localparam int GW_W       = 12;
  localparam int SUM_W      = 10;
  localparam int N_SLOT     = 8;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;

  localparam logic [GW_W-1:0] GW_RESET = 12'd256;

  // straight cost = sum * 128
  localparam int STRAIGHT_SHIFT = 7;

  // 64 * sqrt(2) in Q7.32, split into two partial products
  localparam int              DIAG_FRAC = 32;
  localparam int              DIAG_K_W  = 39;
  localparam int              DIAG_LO_W = 20;
  localparam int              DIAG_HI_W = DIAG_K_W - DIAG_LO_W;
  localparam logic [DIAG_K_W-1:0]  DIAG_K    = 39'd388736063997;
  localparam logic [DIAG_HI_W-1:0] DIAG_K_HI = DIAG_K[DIAG_K_W-1:DIAG_LO_W];
  localparam logic [DIAG_LO_W-1:0] DIAG_K_LO = DIAG_K[DIAG_LO_W-1:0];
  localparam int              PROD_W    = SUM_W + DIAG_K_W;

  // emission order
  typedef enum logic [2:0] {
    SLOT_N, SLOT_NE, SLOT_NW, SLOT_S, SLOT_SE, SLOT_SW, SLOT_E, SLOT_W
  } slot_t;

  typedef struct packed {
    logic [N_SLOT-1:0]            mask;
    logic [N_SLOT-1:0][SUM_W-1:0] sums;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

endpackage

// ===== rtl/wgne_front.sv =====
module wgne_front import wgne_pkg::*; #(
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic [IN_DATA_W-1:0] in_data,
  input  logic [GW_W-1:0]      grid_width,
  output desc_t                desc,
  output logic [ID_BITS-1:0]   id_c,
  output logic [ID_BITS-1:0]   id_n,
  output logic [ID_BITS-1:0]   id_s
);

  localparam int WB_EFF = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam logic [WEIGHT_W:0]   W_MASK_X = ((WEIGHT_W+1)'(1) << WB_EFF) - (WEIGHT_W+1)'(1);
  localparam logic [WEIGHT_W-1:0] W_MASK   = W_MASK_X[WEIGHT_W-1:0];

  logic [WEIGHT_W-1:0] wc, wn, ws, we, ww, wne, wnw, wse, wsw;
  logic [ID_BITS-1:0]  gwx;
  logic                nz_n, nz_s, nz_e, nz_w;

  assign wc  = in_data[27:20] & W_MASK;
  assign wn  = in_data[35:28] & W_MASK;
  assign ws  = in_data[43:36] & W_MASK;
  assign we  = in_data[51:44] & W_MASK;
  assign ww  = in_data[59:52] & W_MASK;
  assign wne = in_data[67:60] & W_MASK;
  assign wnw = in_data[75:68] & W_MASK;
  assign wse = in_data[83:76] & W_MASK;
  assign wsw = in_data[91:84] & W_MASK;

  assign nz_n = (wn != '0);
  assign nz_s = (ws != '0);
  assign nz_e = (we != '0);
  assign nz_w = (ww != '0);

  assign gwx  = ID_BITS'(grid_width);
  assign id_c = ID_BITS'(in_data[NODE_W-1:0]);
  assign id_n = id_c - gwx;
  assign id_s = id_c + gwx;

  always_comb begin
    desc.mask[SLOT_N]  = nz_n;
    desc.mask[SLOT_NE] = nz_n && (wne != '0) && nz_e;
    desc.mask[SLOT_NW] = nz_n && (wnw != '0) && nz_w;
    desc.mask[SLOT_S]  = nz_s;
    desc.mask[SLOT_SE] = nz_s && (wse != '0) && nz_e;
    desc.mask[SLOT_SW] = nz_s && (wsw != '0) && nz_w;
    desc.mask[SLOT_E]  = nz_e;
    desc.mask[SLOT_W]  = nz_w;

    desc.sums[SLOT_N]  = SUM_W'(wc) + SUM_W'(wn);
    desc.sums[SLOT_S]  = SUM_W'(wc) + SUM_W'(ws);
    desc.sums[SLOT_E]  = SUM_W'(wc) + SUM_W'(we);
    desc.sums[SLOT_W]  = SUM_W'(wc) + SUM_W'(ww);
    desc.sums[SLOT_NE] = SUM_W'(wc) + SUM_W'(wn) + SUM_W'(we) + SUM_W'(wne);
    desc.sums[SLOT_NW] = SUM_W'(wc) + SUM_W'(wn) + SUM_W'(ww) + SUM_W'(wnw);
    desc.sums[SLOT_SE] = SUM_W'(wc) + SUM_W'(ws) + SUM_W'(we) + SUM_W'(wse);
    desc.sums[SLOT_SW] = SUM_W'(wc) + SUM_W'(ws) + SUM_W'(ww) + SUM_W'(wsw);
  end

endmodule

// ===== rtl/wgne_queue.sv =====
module wgne_queue import wgne_pkg::*; #(
  parameter int DATA_W = DESC_W,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/wgne_back.sv =====
module wgne_back import wgne_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  desc_t                 q_desc,
  input  logic [ID_BITS-1:0]    q_id_c,
  input  logic [ID_BITS-1:0]    q_id_n,
  input  logic [ID_BITS-1:0]    q_id_s,
  output logic                  q_pop,
  output logic                  busy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int PAD_W = OUT_DATA_W - NODE_W - COST_W;

  // current item
  logic                         cur_valid_r, cur_valid_nxt;
  logic [N_SLOT-1:0]            cur_mask_r, cur_mask_nxt;
  logic [N_SLOT-1:0][SUM_W-1:0] cur_sums_r;
  logic [ID_BITS-1:0]           cur_id_c_r, cur_id_n_r, cur_id_s_r;

  // stage A: slot picked
  logic               a_valid_r, a_diag_r, a_last_r;
  logic [SUM_W-1:0]   a_sum_r;
  logic [ID_BITS-1:0] a_id_r;

  // stage B: partial products
  logic                       b_valid_r, b_diag_r, b_last_r;
  logic [SUM_W-1:0]           b_sum_r;
  logic [SUM_W+DIAG_HI_W-1:0] b_phi_r;
  logic [SUM_W+DIAG_LO_W-1:0] b_plo_r;
  logic [ID_BITS-1:0]         b_id_r;

  // output register
  logic              o_valid_r, o_last_r;
  logic [COST_W-1:0] o_cost_r, cost_nxt;
  logic [NODE_W-1:0] o_id_r;

  logic               en, emit, last;
  logic [2:0]         sel_idx;
  slot_t              sel;
  logic [N_SLOT-1:0]  rem;
  logic               sel_diag;
  logic [ID_BITS-1:0] sel_id;
  logic [PROD_W-1:0]  rnd;

  assign en    = !o_valid_r || out_tready;
  assign emit  = en && cur_valid_r;
  assign q_pop = q_valid && (!cur_valid_r || (emit && last));
  assign busy  = cur_valid_r;

  always_comb begin
    sel_idx = '0;
    for (int i = N_SLOT - 1; i >= 0; i--) begin
      if (cur_mask_r[i]) sel_idx = 3'(i);
    end
  end

  assign sel  = slot_t'(sel_idx);
  assign rem  = cur_mask_r & ~(N_SLOT'(1) << sel_idx);
  assign last = (rem == '0);

  always_comb begin
    unique case (sel)
      SLOT_N:  begin sel_id = cur_id_n_r;        sel_diag = 1'b0; end
      SLOT_NE: begin sel_id = cur_id_n_r + 1'b1; sel_diag = 1'b1; end
      SLOT_NW: begin sel_id = cur_id_n_r - 1'b1; sel_diag = 1'b1; end
      SLOT_S:  begin sel_id = cur_id_s_r;        sel_diag = 1'b0; end
      SLOT_SE: begin sel_id = cur_id_s_r + 1'b1; sel_diag = 1'b1; end
      SLOT_SW: begin sel_id = cur_id_s_r - 1'b1; sel_diag = 1'b1; end
      SLOT_E:  begin sel_id = cur_id_c_r + 1'b1; sel_diag = 1'b0; end
      SLOT_W:  begin sel_id = cur_id_c_r - 1'b1; sel_diag = 1'b0; end
    endcase
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_mask_nxt  = cur_mask_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cur_mask_nxt  = q_desc.mask;
    end else if (emit) begin
      cur_valid_nxt = !last;
      cur_mask_nxt  = rem;
    end
  end

  // round to nearest: add half an lsb at the Q32 point
  assign rnd = (PROD_W'(b_phi_r) << DIAG_LO_W) + PROD_W'(b_plo_r)
             + (PROD_W'(1) << (DIAG_FRAC - 1));
  assign cost_nxt = b_diag_r ? rnd[DIAG_FRAC +: COST_W]
                             : (COST_W'(b_sum_r) << STRAIGHT_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_mask_r  <= '0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      o_valid_r   <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cur_mask_r  <= cur_mask_nxt;
      if (en) begin
        a_valid_r <= emit;
        b_valid_r <= a_valid_r;
        o_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_sums_r <= q_desc.sums;
      cur_id_c_r <= q_id_c;
      cur_id_n_r <= q_id_n;
      cur_id_s_r <= q_id_s;
    end
    if (en) begin
      a_diag_r <= sel_diag;
      a_last_r <= last;
      a_sum_r  <= cur_sums_r[sel_idx];
      a_id_r   <= sel_id;
      b_diag_r <= a_diag_r;
      b_last_r <= a_last_r;
      b_sum_r  <= a_sum_r;
      b_phi_r  <= a_sum_r * DIAG_K_HI;
      b_plo_r  <= a_sum_r * DIAG_K_LO;
      b_id_r   <= a_id_r;
      o_last_r <= b_last_r;
      o_cost_r <= cost_nxt;
      o_id_r   <= NODE_W'(b_id_r);
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, o_cost_r, o_id_r};

endmodule

// ===== rtl/weighted_grid_neighbour_expander_unit.sv =====
// An input beat passes queue, current item, stage A, stage B and output register.
// Throughput: one result beat per cycle while out_tready is high and cells are waiting;
// a cell holds the back end for its results (at most 8); a cell with none is dropped.
// A 2-entry queue between classifier and emitter; input is taken while it has room.
// Reset: synchronous, active low; clears queue and pipeline, grid_width returns to 256.
`include "weighted_grid_neighbour_expander_unit_macros.svh"

module weighted_grid_neighbour_expander_unit import wgne_pkg::*; #(
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // node_id[19:0], weight_center[27:20], weight_north[35:28], weight_south[43:36],
  // weight_east[51:44], weight_west[59:52], weight_northeast[67:60],
  // weight_northwest[75:68], weight_southeast[83:76], weight_southwest[91:84]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // neighbour_id[19:0], step_cost[36:20]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [GW_W-1:0]       cfg_data
);

  localparam int Q_W = DESC_W + 3 * ID_BITS;

  logic [GW_W-1:0]    gw_r;
  desc_t              f_desc, q_desc;
  logic [ID_BITS-1:0] f_id_c, f_id_n, f_id_s;
  logic               q_push, q_full, q_pop, q_valid, back_busy;
  logic [Q_W-1:0]     q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gw_r <= cfg_data;
    end
  end

  wgne_front #(
    .ID_BITS     (ID_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .in_data    (in_tdata),
    .grid_width (gw_r),
    .desc       (f_desc),
    .id_c       (f_id_c),
    .id_n       (f_id_n),
    .id_s       (f_id_s)
  );

  assign in_tready = !q_full;
  // cells with no open neighbour are dropped here
  assign q_push    = in_tvalid && in_tready && (f_desc.mask != '0);

  wgne_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_id_s, f_id_n, f_id_c, f_desc}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  assign q_desc = desc_t'(q_rdata[DESC_W-1:0]);

  wgne_back #(
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_desc     (q_desc),
    .q_id_c     (q_rdata[DESC_W +: ID_BITS]),
    .q_id_n     (q_rdata[DESC_W + ID_BITS +: ID_BITS]),
    .q_id_s     (q_rdata[DESC_W + 2 * ID_BITS +: ID_BITS]),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `WGNE_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
  `WGNE_ASSERT_IMPL(a_busy_from_pop, $rose(back_busy), $past(q_pop), "emitter started without pop")
  `WGNE_ASSERT_IMPL(a_full_implies_busy, !in_tready, back_busy, "queue full while emitter idle")
  `WGNE_ASSERT_NEXT(a_idle_loads, q_valid && !back_busy, back_busy, "emitter did not load")

endmodule

// ===== bench/tb_weighted_grid_neighbour_expander_unit.sv =====
module tb_weighted_grid_neighbour_expander_unit;
  import wgne_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 12;
  localparam int PER_PHASE   = 24;
  localparam int N_ROWS      = 14;
  localparam int N_PHASES    = 5;

  // packed so that node_id lands in the low bits of in_tdata
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_southwest;
    logic [WEIGHT_W-1:0] weight_southeast;
    logic [WEIGHT_W-1:0] weight_northwest;
    logic [WEIGHT_W-1:0] weight_northeast;
    logic [WEIGHT_W-1:0] weight_west;
    logic [WEIGHT_W-1:0] weight_east;
    logic [WEIGHT_W-1:0] weight_south;
    logic [WEIGHT_W-1:0] weight_north;
    logic [WEIGHT_W-1:0] weight_center;
    logic [NODE_W-1:0]   node_id;
  } cell_t;

  typedef struct packed {
    logic [NODE_W-1:0] nid;
    logic [COST_W-1:0] cost;
    logic              last;
  } hop_t;

  typedef struct {
    cell_t stim;
    int    n_typed;  // -1: predicted
    hop_t  hop;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [GW_W-1:0]       cfg_data;

  logic [GW_W-1:0] grid_width;
  hop_t            hop_q[$];
  bit              steady;
  int              errors;
  int              cells_sent;
  int              hops_seen;
  int              widths_tried;
  int              quiet;

  row_t plan [N_ROWS] = '{
    '{'{node_id: 20'h12345, default: 8'd0}, 0, '{default: 0}},
    '{'{node_id: 20'h00000, weight_center: 8'd1, weight_north: 8'd1, default: 8'd0},
      1, '{20'hFFF00, 17'd256, 1'b1}},
    '{'{node_id: 20'hFFFFF, weight_center: 8'd255, weight_south: 8'd255, default: 8'd0},
      1, '{20'h000FF, 17'd65280, 1'b1}},
    '{'{node_id: 20'hFFFFF, weight_east: 8'd255, default: 8'd0},
      1, '{20'h00000, 17'd32640, 1'b1}},
    '{'{node_id: 20'h00000, weight_west: 8'd1, default: 8'd0},
      1, '{20'hFFFFF, 17'd128, 1'b1}},
    '{'{node_id: 20'h00400, weight_center: 8'd3, weight_north: 8'd5,
        weight_northeast: 8'd9, weight_northwest: 8'd9, default: 8'd0},
      1, '{20'h00300, 17'd1024, 1'b1}},
    '{'{node_id: 20'h80000, default: 8'hFF}, -1, '{default: 0}},
    '{'{node_id: 20'h00000, default: 8'h01}, -1, '{default: 0}},
    '{'{node_id: 20'h00100, weight_center: 8'd10, weight_east: 8'd7,
        weight_northeast: 8'd200, weight_southeast: 8'd200, default: 8'd0},
      -1, '{default: 0}},
    '{'{node_id: 20'h00200, weight_center: 8'd4, weight_south: 8'd9, weight_east: 8'd3,
        weight_west: 8'd6, weight_southeast: 8'd250, weight_southwest: 8'd1,
        default: 8'd0}, -1, '{default: 0}},
    '{'{node_id: 20'h00050, weight_north: 8'd20, weight_east: 8'd30, weight_west: 8'd50,
        weight_northeast: 8'd40, default: 8'd0}, -1, '{default: 0}},
    '{'{node_id: 20'hFFF80, weight_center: 8'd0, default: 8'hFF}, -1, '{default: 0}},
    '{'{node_id: 20'hAAAAA, weight_center: 8'h55, weight_north: 8'hAA,
        weight_south: 8'h55, weight_east: 8'hAA, weight_west: 8'h55,
        weight_northeast: 8'hAA, weight_northwest: 8'h55, weight_southeast: 8'hAA,
        weight_southwest: 8'h55}, -1, '{default: 0}},
    '{'{node_id: 20'h55555, weight_center: 8'hAA, weight_north: 8'h55,
        weight_south: 8'hAA, weight_east: 8'h55, weight_west: 8'hAA,
        weight_northeast: 8'h55, weight_northwest: 8'hAA, weight_southeast: 8'h55,
        weight_southwest: 8'hAA}, -1, '{default: 0}}
  };

  weighted_grid_neighbour_expander_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned lo = 0;
    longint unsigned hi = 64'hFFFF_FFFF;
    longint unsigned mid;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [COST_W-1:0] straight_cost(input int a, input int b);
    return COST_W'((a + b) * 128);
  endfunction

  // nearest integer to s * 64 * sqrt2; square is 8192 s^2
  function automatic logic [COST_W-1:0] diagonal_cost(input int s);
    longint unsigned sq;
    longint unsigned f;
    sq = 64'd8192 * longint'(s) * longint'(s);
    f  = floor_root(sq);
    if (sq > f * f + f) f = f + 1;
    return COST_W'(f);
  endfunction

  function automatic void expand_cell(input cell_t c);
    logic [NODE_W-1:0] idn;
    logic [NODE_W-1:0] ids;
    int wc, wn, ws, we, ww, wne, wnw, wse, wsw;
    int k;
    wc  = c.weight_center;     wn  = c.weight_north;     ws  = c.weight_south;
    we  = c.weight_east;       ww  = c.weight_west;
    wne = c.weight_northeast;  wnw = c.weight_northwest;
    wse = c.weight_southeast;  wsw = c.weight_southwest;
    idn = c.node_id - NODE_W'(grid_width);
    ids = c.node_id + NODE_W'(grid_width);
    k   = 0;
    if (wn != 0) begin
      hop_q.push_back('{idn, straight_cost(wc, wn), 1'b0}); k++;
      if (wne != 0 && we != 0) begin
        hop_q.push_back('{idn + 1'b1, diagonal_cost(wc + wn + we + wne), 1'b0}); k++;
      end
      if (wnw != 0 && ww != 0) begin
        hop_q.push_back('{idn - 1'b1, diagonal_cost(wc + wn + ww + wnw), 1'b0}); k++;
      end
    end
    if (ws != 0) begin
      hop_q.push_back('{ids, straight_cost(wc, ws), 1'b0}); k++;
      if (wse != 0 && we != 0) begin
        hop_q.push_back('{ids + 1'b1, diagonal_cost(wc + ws + we + wse), 1'b0}); k++;
      end
      if (wsw != 0 && ww != 0) begin
        hop_q.push_back('{ids - 1'b1, diagonal_cost(wc + ws + ww + wsw), 1'b0}); k++;
      end
    end
    if (we != 0) begin
      hop_q.push_back('{c.node_id + 1'b1, straight_cost(wc, we), 1'b0}); k++;
    end
    if (ww != 0) begin
      hop_q.push_back('{c.node_id - 1'b1, straight_cost(wc, ww), 1'b0}); k++;
    end
    if (k > 0) hop_q[hop_q.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 35) return 8'hFF;
    if (r < 40) return 8'h01;
    return WEIGHT_W'($urandom_range(1, 255));
  endfunction

  function automatic cell_t pick_cell();
    cell_t c;
    int    r;
    c.weight_center    = WEIGHT_W'($urandom_range(0, 255));
    c.weight_north     = pick_weight();
    c.weight_south     = pick_weight();
    c.weight_east      = pick_weight();
    c.weight_west      = pick_weight();
    c.weight_northeast = pick_weight();
    c.weight_northwest = pick_weight();
    c.weight_southeast = pick_weight();
    c.weight_southwest = pick_weight();
    r = $urandom_range(99);
    if (r < 15)      c.node_id = NODE_W'($urandom_range(0, 4));
    else if (r < 30) c.node_id = 20'hFFFFF - NODE_W'($urandom_range(0, 4));
    else             c.node_id = NODE_W'($urandom);
    // fully blocked cell now and then
    if ($urandom_range(99) < 5) c[IN_DATA_W-5:NODE_W+WEIGHT_W] = '0;
    return c;
  endfunction

  task automatic idle_gap();
    while (!steady && $urandom_range(99) < 35) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_cell(input cell_t c, input int n_typed, input hop_t typed_hop);
    idle_gap();
    in_tdata  = IN_DATA_W'(c);
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (n_typed < 0) expand_cell(c);
    else if (n_typed > 0) hop_q.push_back(typed_hop);
    cells_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (hop_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_width(input logic [GW_W-1:0] w);
    cfg_data  = w;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    grid_width = w;
    widths_tried++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst_n) out_tready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin : result_check
    hop_t want;
    if (rst_n && out_tvalid && out_tready) begin
      hops_seen++;
      if (hop_q.size() == 0) begin
        $error("unexpected beat: id %h cost %0d last %b",
               out_tdata[NODE_W-1:0], out_tdata[NODE_W+COST_W-1:NODE_W], out_tlast);
        errors++;
      end else begin
        want = hop_q.pop_front();
        if (out_tdata[NODE_W-1:0] !== want.nid) begin
          $error("neighbour_id: expected %h, got %h", want.nid, out_tdata[NODE_W-1:0]);
          errors++;
        end
        if (out_tdata[NODE_W+COST_W-1:NODE_W] !== want.cost) begin
          $error("step_cost: expected %0d, got %0d", want.cost,
                 out_tdata[NODE_W+COST_W-1:NODE_W]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    grid_width   = GW_RESET;
    steady       = 1'b0;
    errors       = 0;
    cells_sent   = 0;
    hops_seen    = 0;
    widths_tried = 1;
    quiet        = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_cell(plan[i].stim, plan[i].n_typed, plan[i].hop);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: write_width(12'hFFF);
        1: write_width(12'h000);
        2: write_width(12'h001);
        3: write_width(GW_W'($urandom_range(2, 4094)));
        default: write_width(GW_W'($urandom_range(0, 4095)));
      endcase
      steady = (p == 3);
      for (int j = 0; j < PER_PHASE; j++) send_cell(pick_cell(), -1, '{default: 0});
    end
    steady = 1'b0;
    in_tvalid = 1'b0;

    while (hop_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d cells expanded into %0d neighbour beats across %0d grid widths",
             cells_sent, hops_seen, widths_tried);
    if (errors == 0 && hop_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== weighted_grid_neighbour_expander_unit.f =====
+incdir+rtl
rtl/wgne_pkg.sv
rtl/wgne_front.sv
rtl/wgne_queue.sv
rtl/wgne_back.sv
rtl/weighted_grid_neighbour_expander_unit.sv
bench/tb_weighted_grid_neighbour_expander_unit.sv
